@@ rtl/core/can_bit_timing_calculator_defines.svh @@
// Assertion macros for the CAN bit timing calculator.
// Included by the RTL files that carry concurrent assertions.
`ifndef CAN_BIT_TIMING_CALCULATOR_DEFINES_SVH
`define CAN_BIT_TIMING_CALCULATOR_DEFINES_SVH

// same-cycle implication
`define CBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbt assertion failed");

// next-cycle implication
`define CBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbt assertion failed");

`endif

@@ rtl/core/cbt_pkg.sv @@
// Package for the CAN bit timing calculator: sequencer states, divider
// status type, register indexes and arithmetic constants. No dependencies.
`default_nettype none

package cbt_pkg;

    localparam int DIV_NW = 41;
    localparam int DIV_DW = 30;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_CAND,
        S_STEP,
        S_ROUND,
        S_LIMIT,
        S_RERR,
        S_SPA,
        S_SPB,
        S_SPD,
        S_SPC,
        S_SPEND,
        S_NEXT,
        S_RESULT,
        S_QNS,
        S_RRATE,
        S_OUT,
        S_WAIT
    } t_state;

    localparam logic [2:0] CFG_CLOCK_HZ     = 3'd0;
    localparam logic [2:0] CFG_SEG1_MIN     = 3'd1;
    localparam logic [2:0] CFG_SEG1_MAX     = 3'd2;
    localparam logic [2:0] CFG_SEG2_MIN     = 3'd3;
    localparam logic [2:0] CFG_SEG2_MAX     = 3'd4;
    localparam logic [2:0] CFG_JUMP_MAX     = 3'd5;
    localparam logic [2:0] CFG_PRESCALE_MIN = 3'd6;
    localparam logic [2:0] CFG_PRESCALE_MAX = 3'd7;

    localparam logic [29:0] NO_RERR   = 30'h3FFF_FFFF;
    localparam logic [10:0] NO_PERR   = 11'h7FF;
    localparam logic [19:0] RATE_HI   = 20'd800000;
    localparam logic [19:0] RATE_MID  = 20'd500000;
    localparam logic [9:0]  NOM_HI    = 10'd750;
    localparam logic [9:0]  NOM_MID   = 10'd800;
    localparam logic [9:0]  NOM_LO    = 10'd875;
    localparam logic [9:0]  PT_SCALE  = 10'd1000;
    localparam logic [29:0] NS_PER_S  = 30'd1000000000;
    localparam logic [19:0] QNS_SAT   = 20'hFFFFF;

endpackage

`default_nettype wire

@@ rtl/core/cbt_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// bit timing sequencer. Depends on cbt_pkg.
`default_nettype none

module cbt_divider import cbt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_dividend,
    input  wire logic [DIV_DW-1:0] i_divisor,
    output t_div_stat              o_stat,
    output logic      [DIV_NW-1:0] o_quotient
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_NW-1]} - {1'b0, r_dvs};
    assign ge    = ~trial[DIV_DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? trial[DIV_DW-1:0] : {r_rem[DIV_DW-2:0], r_quo[DIV_NW-1]};
                r_quo <= {r_quo[DIV_NW-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

@@ rtl/core/can_bit_timing_calculator.sv @@
// CAN bit timing calculator top level: search sequencer and datapath.
// Depends on cbt_pkg, cbt_divider and can_bit_timing_calculator_defines.svh.
//
// Usage: a request beat (i_want_rate, i_want_point, i_want_jump) is taken at
// a clock edge with start high and busy low. busy stays high until the
// result is out. The result is shown for one cycle with o_done high; the
// receiver cannot stall and must take it then. o_valid_res low means no
// prescaler fits and every other result field is zero.
// Configuration beats on i_cfg_valid/o_cfg_ready (always ready) write the
// register at i_cfg_index; write only while busy is low.
// Sequencing: every division runs on the one shared 41-step divider, issued
// from its own state. A segment length candidate whose prescaler misses
// the limits stops after the prescaler division, one with a worse rate
// error after the rate division, and one that is split also runs four
// split divisions; BRP_STEP above one adds a rounding state per candidate.
// Candidates run from 2*(seg1_max+seg2_max)+1 down to 2*(seg1_min+seg2_min),
// stopping on an exact match; the final split and two output divisions
// follow. With reset limits there are 46 candidates; a zero bitrate or clock
// skips the search. One request is worked at a time.
// Reset returns to idle with the register defaults.
`default_nettype none

`include "can_bit_timing_calculator_defines.svh"

module can_bit_timing_calculator import cbt_pkg::*; #(
    parameter int BRP_STEP = 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [19:0] i_want_rate,
    input  wire logic [9:0]  i_want_point,
    input  wire logic [3:0]  i_want_jump,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [29:0] i_cfg_data,
    output logic             o_done,
    output logic             o_valid_res,
    output logic [10:0]      o_prescale,
    output logic [4:0]       o_prop_len,
    output logic [5:0]       o_phase1_len,
    output logic [5:0]       o_phase2_len,
    output logic [3:0]       o_jump_len,
    output logic [9:0]       o_real_point,
    output logic [29:0]      o_real_rate,
    output logic [19:0]      o_quantum_ns,
    output logic [7:0]       o_timing_byte0,
    output logic [6:0]       o_timing_byte1
);

    localparam int STEP_W = $clog2(BRP_STEP + 1);
    localparam int RCP_SH = 17;
    localparam logic [17:0] RCP_M = 18'((2 ** RCP_SH + BRP_STEP - 1) / BRP_STEP);

    t_state r_state, n_state, r_ret, n_ret;

    logic [29:0] r_clock_hz;
    logic [5:0]  r_seg1_min, r_seg1_max, r_seg2_min, r_seg2_max;
    logic [3:0]  r_jump_max;
    logic [10:0] r_pmin, r_pmax;

    logic [19:0] r_rate;
    logic [9:0]  r_nom;
    logic [3:0]  r_jreq;
    logic [7:0]  r_t, r_tlo;
    logic [30:0] r_brp;
    logic [29:0] r_rerr, r_best_rerr;
    logic [10:0] r_best_perr, r_win_brp, r_sp_err;
    logic [6:0]  r_best_t, r_st, r_s1c, r_s2c, r_h1, r_h2;
    logic        r_i, r_final;
    logic [9:0]  r_sp_pt;
    logic [19:0] r_qns;
    logic        r_done;

    logic              div_start;
    logic [DIV_NW-1:0] div_dividend, div_q;
    logic [DIV_DW-1:0] div_divisor;
    t_div_stat         div_stat;

    logic [7:0]  t_hi, t_lo;
    logic [6:0]  all_w, total_w;
    logic [26:0] rate_mul;
    logic [17:0] brp_all;
    logic [16:0] nom_tot, pt_num;
    logic [40:0] qns_num;
    logic [7:0]  len_w;
    logic [18:0] rr_den;
    logic [29:0] rcp_prod;
    logic [11:0] rcp_q;
    logic [12+STEP_W-1:0] rnd_mul;
    logic [30:0] rnd_brp;
    logic        brp_bad;
    logic [29:0] rerr_w;
    logic [9:0]  nom_w, pt_w, e_w;
    logic signed [9:0] s1a, s2a, st_s;
    logic [6:0]  s1_w, s2_w;
    logic [3:0]  jump_w;
    logic [10:0] bm1;
    logic [3:0]  jm1;
    logic [6:0]  h1m1, h2m1, ph1_w;

    cbt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    assign t_hi     = {7'(r_seg1_max) + 7'(r_seg2_max), 1'b1};
    assign t_lo     = {7'(r_seg1_min) + 7'(r_seg2_min), 1'b0};
    assign all_w    = r_t[7:1] + 7'd1;
    assign total_w  = r_st + 7'd1;
    assign rate_mul = r_rate * all_w;
    assign brp_all  = r_brp[10:0] * all_w;
    assign nom_tot  = r_nom * total_w;
    assign pt_num   = PT_SCALE * (total_w - r_s2c);
    assign qns_num  = r_win_brp * NS_PER_S;
    assign len_w    = {1'b0, r_h1} + {1'b0, r_h2} + 8'd1;
    assign rr_den   = r_win_brp * len_w;
    // round down to a BRP_STEP multiple; above 4095 the prescaler misses the limits anyway
    assign rcp_prod = r_brp[11:0] * RCP_M;
    assign rcp_q    = rcp_prod[RCP_SH+11:RCP_SH];
    assign rnd_mul  = rcp_q * STEP_W'(BRP_STEP);
    assign rnd_brp  = (r_brp[30:12] != '0) ? r_brp : 31'(rnd_mul);
    assign brp_bad  = (r_brp == '0) || (r_brp < {20'b0, r_pmin}) || (r_brp > {20'b0, r_pmax});
    assign rerr_w   = (div_q[29:0] >= {10'b0, r_rate}) ? div_q[29:0] - {10'b0, r_rate}
                                                       : {10'b0, r_rate} - div_q[29:0];
    assign pt_w     = div_q[9:0];
    assign e_w      = r_nom - pt_w;

    always_comb begin
        if (i_want_point != '0) begin
            nom_w = i_want_point;
        end else if (i_want_rate > RATE_HI) begin
            nom_w = NOM_HI;
        end else if (i_want_rate > RATE_MID) begin
            nom_w = NOM_MID;
        end else begin
            nom_w = NOM_LO;
        end
    end

    // segment split for one rounding choice
    always_comb begin
        st_s = $signed({3'b0, r_st});
        s2a  = $signed({3'b0, total_w}) - $signed({2'b0, div_q[7:0]})
               - $signed({9'b0, r_i});
        if (s2a < $signed({4'b0, r_seg2_min})) begin
            s2a = $signed({4'b0, r_seg2_min});
        end
        if (s2a > $signed({4'b0, r_seg2_max})) begin
            s2a = $signed({4'b0, r_seg2_max});
        end
        if (s2a > st_s) begin
            s2a = st_s;
        end
        s1a = st_s - s2a;
        if (s1a > $signed({4'b0, r_seg1_max})) begin
            s1a = $signed({4'b0, r_seg1_max});
            s2a = st_s - s1a;
        end
        s1_w = s1a[6:0];
        s2_w = s2a[6:0];
    end

    always_comb begin
        if (r_jreq == '0 || r_jump_max == '0) begin
            jump_w = 4'd1;
        end else begin
            jump_w = (r_jreq > r_jump_max) ? r_jump_max : r_jreq;
            if (r_h2 < {3'b0, jump_w}) begin
                jump_w = r_h2[3:0];
            end
        end
    end

    assign bm1   = r_win_brp - 11'd1;
    assign jm1   = jump_w - 4'd1;
    assign h1m1  = r_h1 - 7'd1;
    assign h2m1  = r_h2 - 7'd1;
    assign ph1_w = r_h1 - {1'b0, r_h1[6:1]};

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_INIT;
            end
            S_INIT: begin
                if (r_rate == '0 || r_clock_hz == '0 || t_hi < t_lo) n_state = S_RESULT;
                else n_state = S_CAND;
            end
            S_CAND: begin
                n_state = S_WAIT;
                n_ret   = S_STEP;
            end
            S_STEP: begin
                n_state = (BRP_STEP > 1) ? S_ROUND : S_LIMIT;
            end
            S_ROUND: n_state = S_LIMIT;
            S_LIMIT: begin
                if (brp_bad) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_WAIT;
                    n_ret   = S_RERR;
                end
            end
            S_RERR: begin
                n_state = (rerr_w > r_best_rerr) ? S_NEXT : S_SPA;
            end
            S_SPA: begin
                n_state = S_WAIT;
                n_ret   = S_SPB;
            end
            S_SPB: n_state = S_SPD;
            S_SPD: begin
                n_state = S_WAIT;
                n_ret   = S_SPC;
            end
            S_SPC: n_state = r_i ? S_SPEND : S_SPA;
            S_SPEND: begin
                if (r_final) n_state = S_QNS;
                else if (r_sp_err > r_best_perr) n_state = S_NEXT;
                else if (r_rerr == '0 && r_sp_err == '0) n_state = S_RESULT;
                else n_state = S_NEXT;
            end
            S_NEXT: n_state = (r_t == r_tlo) ? S_RESULT : S_CAND;
            S_RESULT: n_state = (r_win_brp == '0) ? S_IDLE : S_SPA;
            S_QNS: begin
                n_state = S_WAIT;
                n_ret   = S_RRATE;
            end
            S_RRATE: begin
                n_state = S_WAIT;
                n_ret   = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            S_WAIT: begin
                if (div_stat.done) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {11'b0, r_clock_hz};
        div_divisor  = {3'b0, rate_mul};
        unique case (r_state)
            S_CAND: begin
                div_start = 1'b1;
            end
            S_LIMIT: begin
                div_start   = ~brp_bad;
                div_divisor = {12'b0, brp_all};
            end
            S_SPA: begin
                div_start    = 1'b1;
                div_dividend = {24'b0, nom_tot};
                div_divisor  = {20'b0, PT_SCALE};
            end
            S_SPD: begin
                div_start    = 1'b1;
                div_dividend = {24'b0, pt_num};
                div_divisor  = {23'b0, total_w};
            end
            S_QNS: begin
                div_start    = 1'b1;
                div_dividend = qns_num;
                div_divisor  = r_clock_hz;
            end
            S_RRATE: begin
                div_start   = 1'b1;
                div_divisor = {11'b0, rr_den};
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_done     <= 1'b0;
            r_clock_hz <= 30'd100000000;
            r_seg1_min <= 6'd1;
            r_seg1_max <= 6'd16;
            r_seg2_min <= 6'd1;
            r_seg2_max <= 6'd8;
            r_jump_max <= 4'd4;
            r_pmin     <= 11'd1;
            r_pmax     <= 11'd64;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_done  <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CLOCK_HZ:     r_clock_hz <= i_cfg_data;
                    CFG_SEG1_MIN:     r_seg1_min <= i_cfg_data[5:0];
                    CFG_SEG1_MAX:     r_seg1_max <= i_cfg_data[5:0];
                    CFG_SEG2_MIN:     r_seg2_min <= i_cfg_data[5:0];
                    CFG_SEG2_MAX:     r_seg2_max <= i_cfg_data[5:0];
                    CFG_JUMP_MAX:     r_jump_max <= i_cfg_data[3:0];
                    CFG_PRESCALE_MIN: r_pmin     <= i_cfg_data[10:0];
                    CFG_PRESCALE_MAX: r_pmax     <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_rate      <= i_want_rate;
                        r_nom       <= nom_w;
                        r_jreq      <= i_want_jump;
                        r_best_rerr <= NO_RERR;
                        r_best_perr <= NO_PERR;
                        r_win_brp   <= '0;
                        r_best_t    <= '0;
                        r_h1        <= '0;
                        r_h2        <= '0;
                    end
                end
                S_INIT: begin
                    r_t   <= t_hi;
                    r_tlo <= t_lo;
                end
                S_STEP:  r_brp <= div_q[30:0] + {30'b0, r_t[0]};
                S_ROUND: r_brp <= rnd_brp;
                S_RERR: begin
                    r_rerr <= rerr_w;
                    if (rerr_w < r_best_rerr) r_best_perr <= NO_PERR;
                    r_st     <= r_t[7:1];
                    r_i      <= 1'b0;
                    r_final  <= 1'b0;
                    r_sp_err <= NO_PERR;
                    r_sp_pt  <= '0;
                end
                S_SPB: begin
                    r_s1c <= s1_w;
                    r_s2c <= s2_w;
                end
                S_SPC: begin
                    if (pt_w <= r_nom && {1'b0, e_w} < r_sp_err) begin
                        r_sp_err <= {1'b0, e_w};
                        r_sp_pt  <= pt_w;
                        r_h1     <= r_s1c;
                        r_h2     <= r_s2c;
                    end
                    r_i <= 1'b1;
                end
                S_SPEND: begin
                    if (!r_final && r_sp_err <= r_best_perr) begin
                        r_best_perr <= r_sp_err;
                        r_best_rerr <= r_rerr;
                        r_best_t    <= r_st;
                        r_win_brp   <= r_brp[10:0];
                    end
                end
                S_NEXT: r_t <= r_t - 8'd1;
                S_RESULT: begin
                    if (r_win_brp == '0) begin
                        r_done         <= 1'b1;
                        o_valid_res    <= 1'b0;
                        o_prescale     <= '0;
                        o_prop_len     <= '0;
                        o_phase1_len   <= '0;
                        o_phase2_len   <= '0;
                        o_jump_len     <= '0;
                        o_real_point   <= '0;
                        o_real_rate    <= '0;
                        o_quantum_ns   <= '0;
                        o_timing_byte0 <= '0;
                        o_timing_byte1 <= '0;
                    end else begin
                        r_st     <= r_best_t;
                        r_i      <= 1'b0;
                        r_final  <= 1'b1;
                        r_sp_err <= NO_PERR;
                        r_sp_pt  <= '0;
                    end
                end
                S_RRATE: r_qns <= (div_q > {21'b0, QNS_SAT}) ? QNS_SAT : div_q[19:0];
                S_OUT: begin
                    r_done         <= 1'b1;
                    o_valid_res    <= 1'b1;
                    o_prescale     <= r_win_brp;
                    o_prop_len     <= r_h1[5:1];
                    o_phase1_len   <= ph1_w[5:0];
                    o_phase2_len   <= r_h2[5:0];
                    o_jump_len     <= jump_w;
                    o_real_point   <= r_sp_pt;
                    o_real_rate    <= div_q[29:0];
                    o_quantum_ns   <= r_qns;
                    o_timing_byte0 <= {jm1[1:0], bm1[5:0]};
                    o_timing_byte1 <= {h2m1[2:0], h1m1[3:0]};
                end
                default: ;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;

    `CBT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `CBT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `CBT_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, o_done && !o_valid_res, (o_prescale == '0) && (o_real_rate == '0))
    `CBT_ASSERT_IMP(a_div_free, i_clk, i_rst_n, div_start, !div_stat.busy)

endmodule

`default_nettype wire
